### hdl/ftrm_pkg.sv
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared types and constants of the fan tach speed meter.
// ----------------------------------------------------------------------------
package ftrm_pkg;

	localparam int TIME_IN_W  = 32;
	localparam int RPM_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int ALPHA_W    = 17;
	localparam int PPR_W      = 5;
	localparam int MS_W       = 16;
	localparam int SCALE_W    = 26;
	localparam int TMO_W      = 26;
	localparam int AVG_W      = 32;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PPR       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd4;

	localparam logic [MS_W-1:0]    RST_MIN_PULSE = 16'd500;
	localparam logic [MS_W-1:0]    RST_UPDATE    = 16'd1000;
	localparam logic [MS_W-1:0]    RST_TIMEOUT   = 16'd2000;
	localparam logic [PPR_W-1:0]   RST_PPR       = 5'd2;
	localparam logic [ALPHA_W-1:0] RST_ALPHA     = 17'd19661;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
	localparam logic [SCALE_W-1:0] RPM_SCALE = 26'd60000000;
	localparam logic [9:0]         MS_TO_US  = 10'd1000;
	localparam logic [15:0]        HALF_LSB  = 16'h8000;

	// divider steps: one saturation probe, then one step per quotient bit
	localparam logic [4:0] DIV_TOP = 5'd16;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMA_MUL,
		ST_EMA_ADD,
		ST_ROUND,
		ST_EMIT
	} ftrm_state_t;

	typedef struct packed {
		logic latch_in;
		logic do_edge;
		logic close_empty;
		logic close_full;
		logic div_start;
		logic ema_mul;
		logic ema_add;
		logic round_out;
		logic load_out;
	} ftrm_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic due;
		logic count_zero;
	} ftrm_stat_t;

endpackage

### hdl/ftrm_if.sv
// ----------------------------------------------------------------------------
// ftrm_if
// Valid/ready channels of the fan tach speed meter.
// ----------------------------------------------------------------------------
interface ftrm_item_if import ftrm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [TIME_IN_W-1:0] time_us;
	logic [TIME_IN_W-1:0] time_ms;

	modport source (output valid, command, time_us, time_ms, input ready);
	modport sink (input valid, command, time_us, time_ms, output ready);
endinterface

interface ftrm_result_if import ftrm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RPM_W-1:0] rpm;
	logic             fresh;
	logic             stopped;

	modport source (output valid, rpm, fresh, stopped, input ready);
	modport sink (input valid, rpm, fresh, stopped, output ready);
endinterface

interface ftrm_cfg_if import ftrm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/ftrm_div.sv
// ----------------------------------------------------------------------------
// ftrm_div
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
module ftrm_div import ftrm_pkg::*; #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [RPM_W-1:0] quot
);

	localparam int SHW = DEN_W + RPM_W;
	localparam int CW  = (NUM_W > SHW) ? NUM_W : SHW;

	logic             busy_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dsh_q;
	logic [RPM_W-1:0] q_q;
	logic             sat_q;
	logic             ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_TOP;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// first step probes den<<16: quotient would not fit, so saturate.
	// a zero divisor lands there as well.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(num);
			dsh_q <= CW'(den) << RPM_W;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q == DIV_TOP) begin
				sat_q <= ge;
			end else begin
				q_q <= {q_q[RPM_W-2:0], ge};
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = sat_q ? '1 : q_q;

endmodule

### hdl/ftrm_ctrl.sv
// ----------------------------------------------------------------------------
// ftrm_ctrl
// Sequencer: item intake, window close, divide, average, result handoff.
// ----------------------------------------------------------------------------
module ftrm_ctrl import ftrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  ftrm_stat_t stat,
	input  logic       div_done,
	output ftrm_cmd_t  cmd
);

	ftrm_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (!stat.is_tick || !stat.due) state_d = ST_IDLE;
				else if (stat.count_zero)       state_d = ST_EMIT;
				else                            state_d = ST_DIV_START;
			end
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = ST_EMA_MUL;
			end
			ST_EMA_MUL: state_d = ST_EMA_ADD;
			ST_EMA_ADD: state_d = ST_ROUND;
			ST_ROUND:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready   = 1'b1;
				cmd.latch_in = item_valid;
			end
			ST_DECODE: begin
				cmd.do_edge     = !stat.is_tick;
				cmd.close_empty = stat.is_tick && stat.due && stat.count_zero;
				cmd.close_full  = stat.is_tick && stat.due && !stat.count_zero;
			end
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV_WAIT:  cmd = '0;
			ST_EMA_MUL:   cmd.ema_mul   = 1'b1;
			ST_EMA_ADD:   cmd.ema_add   = 1'b1;
			ST_ROUND:     cmd.round_out = 1'b1;
			ST_EMIT:      cmd.load_out  = slot_free;
			default:      cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/ftrm_dp.sv
// ----------------------------------------------------------------------------
// ftrm_dp
// Datapath: config registers, edge accumulation, window state, average.
// ----------------------------------------------------------------------------
module ftrm_dp import ftrm_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32,
	parameter int NUM_W      = SCALE_W + COUNT_BITS,
	parameter int DEN_W      = TIME_BITS + PPR_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ftrm_cmd_t             cmd,
	output ftrm_stat_t            stat,
	input  logic                  in_command,
	input  logic [TIME_IN_W-1:0]  in_time_us,
	input  logic [TIME_IN_W-1:0]  in_time_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [NUM_W-1:0]      num,
	output logic [DEN_W-1:0]      den,
	input  logic [RPM_W-1:0]      div_quot,
	output logic [RPM_W-1:0]      rpm,
	output logic                  fresh,
	output logic                  stopped
);

	localparam int P1_W = AVG_W + ALPHA_W;
	localparam int P2_W = RPM_W + ALPHA_W;
	localparam int EW   = P1_W + 2;

	logic [MS_W-1:0]    min_pulse_q, update_q, timeout_q;
	logic [PPR_W-1:0]   ppr_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic                  cmd_q;
	logic [TIME_BITS-1:0]  tus_q, tms_q;

	logic [TIME_BITS-1:0]  sum_q, anchor_q, wstart_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  anchor_valid_q;
	logic [AVG_W-1:0]      avg_q;
	logic [RPM_W-1:0]      speed_q;
	logic                  fresh_q, stopped_q;
	logic [NUM_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic [P1_W-1:0]       p1_q;
	logic [P2_W-1:0]       p2_q;
	logic                  avg_zero_q;
	logic [RPM_W-1:0]      rpm_q;
	logic                  fresh_out_q, stopped_out_q;

	logic [TIME_BITS-1:0]  dt, elapsed;
	logic [TIME_BITS:0]    sum_ext;
	logic [TIME_BITS-1:0]  sum_sat;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  rejected;
	logic [TMO_W-1:0]      tmo_us;
	logic                  stop_now;
	logic [ALPHA_W-1:0]    alpha_c, alpha_inv;
	logic [EW-1:0]         ema_sum;
	logic [AVG_W:0]        rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= RST_MIN_PULSE;
			update_q    <= RST_UPDATE;
			timeout_q   <= RST_TIMEOUT;
			ppr_q       <= RST_PPR;
			alpha_q     <= RST_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_PULSE: min_pulse_q <= cfg_data[MS_W-1:0];
				CFG_UPDATE:    update_q    <= cfg_data[MS_W-1:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data[MS_W-1:0];
				CFG_PPR:       ppr_q       <= cfg_data[PPR_W-1:0];
				CFG_ALPHA:     alpha_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q <= in_command;
			tus_q <= in_time_us[TIME_BITS-1:0];
			tms_q <= in_time_ms[TIME_BITS-1:0];
		end
	end

	// time differences wrap modulo 2^TIME_BITS
	assign dt        = tus_q - anchor_q;
	assign elapsed   = tms_q - wstart_q;
	assign rejected  = anchor_valid_q && (dt < TIME_BITS'(min_pulse_q));
	assign sum_ext   = {1'b0, sum_q} + {1'b0, dt};
	assign sum_sat   = sum_ext[TIME_BITS] ? '1 : sum_ext[TIME_BITS-1:0];
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_BITS'(1);
	assign tmo_us    = TMO_W'(timeout_q) * TMO_W'(MS_TO_US);
	assign stop_now  = !anchor_valid_q || (32'(dt) > 32'(tmo_us));

	assign alpha_c   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_inv = ALPHA_ONE - alpha_c;
	assign ema_sum   = EW'(p1_q) + (EW'(p2_q) << RPM_W) + EW'(HALF_LSB);
	assign rnd       = {1'b0, avg_q} + (AVG_W + 1)'(HALF_LSB);

	assign stat.is_tick    = (cmd_q == CMD_TICK);
	assign stat.due        = (elapsed >= TIME_BITS'(update_q));
	assign stat.count_zero = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			count_q        <= '0;
			anchor_q       <= '0;
			anchor_valid_q <= 1'b0;
			wstart_q       <= '0;
			avg_q          <= '0;
			speed_q        <= '0;
		end else if (cmd.do_edge) begin
			if (!rejected) begin
				if (anchor_valid_q) begin
					sum_q   <= sum_sat;
					count_q <= count_inc;
				end
				anchor_q       <= tus_q;
				anchor_valid_q <= 1'b1;
			end
		end else if (cmd.close_empty) begin
			wstart_q <= tms_q;
			if (stop_now) begin
				anchor_valid_q <= 1'b0;
				avg_q          <= '0;
				speed_q        <= '0;
			end
		end else if (cmd.close_full) begin
			wstart_q <= tms_q;
			sum_q    <= '0;
			count_q  <= '0;
		end else if (cmd.ema_add) begin
			// first sample seeds the average directly
			avg_q <= avg_zero_q ? {div_quot, {RPM_W{1'b0}}} : ema_sum[AVG_W+RPM_W-1:RPM_W];
		end else if (cmd.round_out) begin
			speed_q <= rnd[AVG_W] ? '1 : rnd[AVG_W-1:RPM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close_empty) begin
			fresh_q   <= 1'b0;
			stopped_q <= stop_now;
		end
		if (cmd.close_full) begin
			num_q <= NUM_W'(RPM_SCALE) * NUM_W'(count_q);
			den_q <= DEN_W'(sum_q) * DEN_W'(ppr_q);
		end
		if (cmd.ema_mul) begin
			p1_q       <= P1_W'(avg_q) * P1_W'(alpha_inv);
			p2_q       <= P2_W'(div_quot) * P2_W'(alpha_c);
			avg_zero_q <= (avg_q == '0);
		end
		if (cmd.round_out) begin
			fresh_q   <= 1'b1;
			stopped_q <= 1'b0;
		end
		if (cmd.load_out) begin
			rpm_q         <= speed_q;
			fresh_out_q   <= fresh_q;
			stopped_out_q <= stopped_q;
		end
	end

	assign num     = num_q;
	assign den     = den_q;
	assign rpm     = rpm_q;
	assign fresh   = fresh_out_q;
	assign stopped = stopped_out_q;

endmodule

### hdl/fan_tach_rpm_meter.sv
// ----------------------------------------------------------------------------
// fan_tach_rpm_meter
// Fan speed from tach edge timestamps, windowed and exponentially averaged.
// ----------------------------------------------------------------------------
//  channel  dir  payload                         transfer
//  item     in   command, time_us, time_ms       valid & ready
//  result   out  rpm, fresh, stopped             valid & ready
//  cfg      in   index, data (5 registers)       valid & ready, always ready
//
//  An edge or a tick that does not close the window passes decode and returns
//  to idle. A tick that closes an empty window goes from decode to emit; one
//  that closes a window with intervals first runs the bit-serial divider
//  (17 steps), the average update (multiply, then add) and the rounding.
//  Items are handled one at a time; a finished result waits in the output
//  register while the next item is taken. No clearing pass after reset.
module fan_tach_rpm_meter import ftrm_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ftrm_item_if.sink     item,
	ftrm_result_if.source result,
	ftrm_cfg_if.sink      cfg
);

	localparam int NUM_W = SCALE_W + COUNT_BITS;
	localparam int DEN_W = TIME_BITS + PPR_W;

	ftrm_cmd_t        cmd;
	ftrm_stat_t       stat;
	logic             div_done;
	logic [RPM_W-1:0] div_quot;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;

	assign cfg.ready = 1'b1;

	ftrm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.stat       (stat),
		.div_done   (div_done),
		.cmd        (cmd)
	);

	ftrm_dp #(
		.COUNT_BITS (COUNT_BITS),
		.TIME_BITS  (TIME_BITS),
		.NUM_W      (NUM_W),
		.DEN_W      (DEN_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (item.command),
		.in_time_us (item.time_us),
		.in_time_ms (item.time_ms),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.num        (num),
		.den        (den),
		.div_quot   (div_quot),
		.rpm        (result.rpm),
		.fresh      (result.fresh),
		.stopped    (result.stopped)
	);

	ftrm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

endmodule

### hdl/ftrm_checker.sv
// ----------------------------------------------------------------------------
// ftrm_checker
// Port-level checks of the fan tach speed meter, bound to the top level.
// ----------------------------------------------------------------------------
module ftrm_checker import ftrm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [RPM_W-1:0] rpm,
	input logic             fresh,
	input logic             stopped,
	input logic             cfg_ready
);

	// result held until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// a stopped report carries zero speed and is never fresh
	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped |-> (rpm == '0) && !fresh)
		else $error("stopped result with speed or fresh flag");

	// one item at a time: intake closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while busy");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind fan_tach_rpm_meter ftrm_checker u_ftrm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.rpm        (result.rpm),
	.fresh      (result.fresh),
	.stopped    (result.stopped),
	.cfg_ready  (cfg.ready)
);

### tb/tb_fan_tach_rpm_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fan_tach_rpm_meter
// Self-checking bench for the fan tach speed meter. A scoreboard class tracks
// anchor, interval sum/count, window and averaged speed, predicts the
// reading of each window-closing tick and checks it against the result channel. Directed
// corners first, then random edge/tick streams over several register
// settings, then a short back-to-back edge burst closed by one tick.
// ----------------------------------------------------------------------------
module tb_fan_tach_rpm_meter;
	import ftrm_pkg::*;

	typedef struct {
		logic [RPM_W-1:0] rpm;
		logic             fresh;
		logic             stopped;
	} reading_t;

	class rpm_tracker;
		logic [15:0]       min_pulse;
		logic [15:0]       window_ms;
		logic [15:0]       timeout_ms;
		logic [PPR_W-1:0]  ppr;
		logic [ALPHA_W-1:0] alpha;

		logic [31:0]       iv_sum;
		logic [15:0]       iv_count;
		logic [31:0]       anchor;
		logic              anchored;
		logic [31:0]       win_start;
		logic [AVG_W-1:0]  avg_q16;
		logic [RPM_W-1:0]  rpm_now;

		reading_t          pending[$];
		int                fails;
		int                shown;

		function new();
			min_pulse  = RST_MIN_PULSE;
			window_ms  = RST_UPDATE;
			timeout_ms = RST_TIMEOUT;
			ppr        = RST_PPR;
			alpha      = RST_ALPHA;
			iv_sum     = '0;
			iv_count   = '0;
			anchor     = '0;
			anchored   = 1'b0;
			win_start  = '0;
			avg_q16    = '0;
			rpm_now    = '0;
			fails      = 0;
			shown      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MIN_PULSE: min_pulse = data[15:0];
				CFG_UPDATE:    window_ms = data[15:0];
				CFG_TIMEOUT:   timeout_ms = data[15:0];
				CFG_PPR:       ppr = data[PPR_W-1:0];
				CFG_ALPHA:     alpha = data[ALPHA_W-1:0];
				default:       ;
			endcase
		endfunction

		// updates state for one item transfer; a closed window queues a reading
		function void take_item(logic cmd, logic [31:0] us, logic [31:0] ms);
			logic [31:0] dt;
			logic [31:0] since;
			logic [31:0] age;
			logic [31:0] limit_us;
			logic [32:0] s;
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] q;
			logic [63:0] x;
			logic [63:0] a;
			logic [63:0] acc;
			logic [15:0] raw;
			reading_t    rd;

			if (cmd == CMD_EDGE) begin
				dt = us - anchor;
				if (anchored && dt < {16'd0, min_pulse})
					return;
				if (anchored) begin
					s = {1'b0, iv_sum} + {1'b0, dt};
					iv_sum = s[32] ? '1 : s[31:0];
					if (iv_count != '1)
						iv_count = iv_count + 16'd1;
				end
				anchor = us;
				anchored = 1'b1;
				return;
			end

			since = ms - win_start;
			if (since < {16'd0, window_ms})
				return;
			win_start = ms;
			rd.fresh = 1'b0;
			rd.stopped = 1'b0;

			if (iv_count == '0) begin
				age = us - anchor;
				limit_us = {16'd0, timeout_ms} * 32'd1000;
				if (!anchored || age > limit_us) begin
					anchored = 1'b0;
					avg_q16 = '0;
					rpm_now = '0;
					rd.stopped = 1'b1;
				end
			end else begin
				num = 64'd60000000 * {48'd0, iv_count};
				den = {32'd0, iv_sum} * {59'd0, ppr};
				if (den == 64'd0) begin
					raw = '1;
				end else begin
					q = num / den;
					raw = (q > 64'd65535) ? 16'hFFFF : q[15:0];
				end
				x = {32'd0, raw, 16'd0};
				a = (alpha > ALPHA_ONE) ? 64'd65536 : {47'd0, alpha};
				iv_sum = '0;
				iv_count = '0;
				if (avg_q16 == '0) begin
					avg_q16 = x[31:0];
				end else begin
					acc = {32'd0, avg_q16} * (64'd65536 - a) + x * a + 64'd32768;
					avg_q16 = acc[47:16];
				end
				q = ({32'd0, avg_q16} + 64'd32768) >> 16;
				rpm_now = (q > 64'd65535) ? 16'hFFFF : q[15:0];
				rd.fresh = 1'b1;
			end
			rd.rpm = rpm_now;
			pending.push_back(rd);
		endfunction

		function void note_fail(string msg);
			fails++;
			if (shown < 10) begin
				shown++;
				$display("mismatch @%0t: %s", $realtime, msg);
			end
		endfunction

		function void check_reading(logic [RPM_W-1:0] rpm, logic fresh, logic stopped);
			reading_t want;
			if (pending.size() == 0) begin
				note_fail($sformatf("unexpected reading rpm=%0d fresh=%0b stopped=%0b",
					rpm, fresh, stopped));
				return;
			end
			want = pending.pop_front();
			if (want.rpm !== rpm || want.fresh !== fresh || want.stopped !== stopped)
				note_fail($sformatf("exp rpm=%0d fresh=%0b stopped=%0b, got rpm=%0d fresh=%0b stopped=%0b",
					want.rpm, want.fresh, want.stopped, rpm, fresh, stopped));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ftrm_item_if   item_ch();
	ftrm_result_if res_ch();
	ftrm_cfg_if    cfg_ch();

	fan_tach_rpm_meter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	rpm_tracker sb = new();

	bit                no_idle;
	longint unsigned   vt_us;
	logic [31:0]       us_off;
	logic [31:0]       ms_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50000000;
		$display("tb_fan_tach_rpm_meter NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side back-pressure
	initial begin
		int n;
		res_ch.ready = 1'b0;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				@(negedge clk) res_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) res_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_reading(res_ch.rpm, res_ch.fresh, res_ch.stopped);
	end

	task automatic send_item(input logic c, input logic [31:0] us, input logic [31:0] ms);
		int gap;
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.command <= c;
		item_ch.time_us <= us;
		item_ch.time_ms <= ms;
		do @(posedge clk); while (!item_ch.ready);
		sb.take_item(c, us, ms);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drive(input logic c, input logic [31:0] us, input logic [31:0] ms);
		send_item(c, us, ms);
	endtask

	// drain all readings, then let a non-reporting item finish
	task automatic settle();
		@(negedge clk) item_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_cfg(input logic [15:0] mp, input logic [15:0] upd,
		input logic [15:0] tmo, input logic [PPR_W-1:0] pr, input logic [ALPHA_W-1:0] al);
		settle();
		write_reg(CFG_MIN_PULSE, {1'b0, mp});
		write_reg(CFG_UPDATE, {1'b0, upd});
		write_reg(CFG_TIMEOUT, {1'b0, tmo});
		write_reg(CFG_PPR, {12'd0, pr});
		write_reg(CFG_ALPHA, al);
	endtask

	// mostly a coherent timeline of edges and ticks, some raw noise
	task automatic random_item(output logic c, output logic [31:0] us, output logic [31:0] ms);
		int r;
		int unsigned step;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			c  = 1'($urandom_range(0, 1));
			us = $urandom;
			ms = $urandom;
			return;
		end
		if (r < 72) begin
			c = CMD_EDGE;
			if (sb.min_pulse != 0 && $urandom_range(0, 9) == 0)
				step = $urandom_range(0, sb.min_pulse - 1);
			else
				step = sb.min_pulse + $urandom_range(0, 2000 + sb.min_pulse);
			// occasional long silence to reach the timeout
			if ($urandom_range(0, 39) == 0)
				step += sb.timeout_ms * 1000 + $urandom_range(0, 5000);
		end else begin
			c = CMD_TICK;
			step = $urandom_range(0, sb.window_ms * 600 + 100);
		end
		vt_us += step;
		us = 32'(vt_us) + us_off;
		ms = 32'(vt_us / 1000) + ms_off;
	endtask

	initial begin
		logic        c;
		logic [31:0] us;
		logic [31:0] ms;

		arst_n          = 1'b0;
		no_idle         = 1'b0;
		vt_us           = 0;
		us_off          = '0;
		ms_off          = '0;
		item_ch.valid   = 1'b0;
		item_ch.command = CMD_EDGE;
		item_ch.time_us = '0;
		item_ch.time_ms = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = CFG_MIN_PULSE;
		cfg_ch.data     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset settings: empty window, glitch, first sample, hold, average, timeout
		drive(CMD_TICK, 32'd0, 32'd0);
		drive(CMD_TICK, 32'd0, 32'd1000);
		drive(CMD_EDGE, 32'd100, 32'd0);
		drive(CMD_EDGE, 32'd300, 32'd0);
		drive(CMD_EDGE, 32'd1100, 32'd0);
		drive(CMD_EDGE, 32'd2100, 32'd0);
		drive(CMD_TICK, 32'd2200, 32'd2000);
		drive(CMD_TICK, 32'd3000, 32'd3000);
		drive(CMD_EDGE, 32'd3500, 32'd0);
		drive(CMD_EDGE, 32'd5500, 32'd0);
		drive(CMD_TICK, 32'd5600, 32'd4000);
		drive(CMD_TICK, 32'hFFFF_FFFF, 32'd6000);
		// time wrap on both counters
		drive(CMD_EDGE, 32'hFFFF_FFFF, 32'd0);
		drive(CMD_EDGE, 32'd0, 32'd0);
		drive(CMD_EDGE, 32'd501, 32'd0);
		drive(CMD_TICK, 32'd501, 32'hFFFF_FFFF);
		drive(CMD_TICK, 32'd0, 32'd0);

		// zero pulse time, zero window, zero ppr, zero alpha
		apply_cfg(16'd0, 16'd0, 16'd1, 5'd0, 17'd0);
		drive(CMD_EDGE, 32'd10, 32'd0);
		drive(CMD_EDGE, 32'd10, 32'd0);
		drive(CMD_TICK, 32'd10, 32'd5);

		// sum saturation, alpha above one, largest registers
		apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 17'h1FFFF);
		drive(CMD_EDGE, 32'd8, 32'd0);
		drive(CMD_EDGE, 32'd7, 32'd0);
		drive(CMD_EDGE, 32'd6, 32'd0);
		drive(CMD_TICK, 32'd6, 32'd65540);

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: apply_cfg(RST_MIN_PULSE, RST_UPDATE, RST_TIMEOUT, RST_PPR, RST_ALPHA);
				1: apply_cfg(16'd0, 16'd1, 16'd1, 5'd1, ALPHA_ONE);
				2: apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd16, 17'd1);
				3: apply_cfg(16'd0, 16'd0, 16'($urandom_range(1, 50)), 5'd0, 17'd0);
				4: apply_cfg(16'($urandom_range(0, 1500)), 16'($urandom_range(1, 30)),
					16'($urandom_range(1, 80)), 5'd31, 17'h1FFFF);
				default: apply_cfg(16'($urandom_range(0, 3000)), 16'($urandom_range(1, 50)),
					16'($urandom_range(1, 100)), 5'($urandom_range(1, 16)),
					17'($urandom_range(1, 65536)));
			endcase
			no_idle = (p == 5);
			if (p % 2 == 1) begin
				us_off = 32'hFFFF_FFFF - $urandom_range(0, 200000);
				ms_off = 32'hFFFF_FFFF - $urandom_range(0, 300);
			end else begin
				us_off = $urandom;
				ms_off = $urandom;
			end
			for (int i = 0; i < 140; i++) begin
				random_item(c, us, ms);
				send_item(c, us, ms);
			end
		end

		// back-to-back edges, then one tick to close the window
		apply_cfg(16'd0, 16'd1, 16'hFFFF, 5'd2, ALPHA_ONE);
		no_idle = 1'b1;
		for (int i = 0; i < 40; i++) begin
			vt_us += 1000;
			drive(CMD_EDGE, 32'(vt_us) + us_off, 32'd0);
		end
		vt_us += 1000;
		drive(CMD_TICK, 32'(vt_us) + us_off, 32'(vt_us / 1000) + ms_off + 32'd1);
		no_idle = 1'b0;

		settle();
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("tb_fan_tach_rpm_meter OK");
		else
			$display("tb_fan_tach_rpm_meter NOT OK");
		$finish;
	end

endmodule
